// ===== rtl/stride_scheduler_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stride scheduler task table
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef STRIDE_SCHEDULER_TABLE_ASSERT_SVH
`define STRIDE_SCHEDULER_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Stride scheduler table package
// Shared codes, widths and types of the stride scheduler task table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned STRIDE_W = 64;
  localparam int unsigned ID_W     = 31;
  localparam int unsigned BIG_W    = 32;
  localparam int unsigned PRIO_W   = 8;

  localparam logic [BIG_W-1:0]  BIG_STRIDE_RST = 32'd65536;
  localparam logic [PRIO_W-1:0] PRIO_RST       = 8'd16;
  localparam logic [ID_W-1:0]   ID_RST         = 31'd1;

  // Register indexes.
  localparam logic REG_BIG_STRIDE = 1'b0;
  localparam logic REG_PRIORITY   = 1'b1;

  // Operation codes.
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_RUN   = 3'd1;
  localparam logic [2:0] OP_YIELD = 3'd2;
  localparam logic [2:0] OP_EXIT  = 3'd3;
  localparam logic [2:0] OP_SCHED = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOSLOT = 2'd1;
  localparam logic [1:0] STAT_NOCUR  = 2'd2;

  // Slot states.
  localparam logic [1:0] SLOT_FREE     = 2'd0;
  localparam logic [1:0] SLOT_USED     = 2'd1;
  localparam logic [1:0] SLOT_RUNNABLE = 2'd2;
  localparam logic [1:0] SLOT_RUNNING  = 2'd3;

  typedef struct packed {
    logic [1:0]          st;
    logic [STRIDE_W-1:0] stride;
    logic [ID_W-1:0]     task_id;
  } slot_entry_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_FIN  = 6'b000100,
    S_ONE  = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } fsm_e;

endpackage

// ===== rtl/sst_div.sv =====
// ----------------------------------------------------------------------------
// Stride step divider
// Restoring radix-2 divider that forms big_stride / priority, one quotient
// bit per cycle. A zero divisor is treated as one.
// ----------------------------------------------------------------------------
module sst_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sst_pkg::BIG_W-1:0]       dividend_i,
  input  logic [sst_pkg::PRIO_W-1:0]      divisor_i,
  output logic [sst_pkg::BIG_W-1:0]       quotient_o,
  output logic                            ready_o
);

  localparam int unsigned CNT_W = $clog2(sst_pkg::BIG_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sst_pkg::BIG_W - 1);

  logic                         busy_q, busy_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [sst_pkg::BIG_W-1:0]    quo_q, quo_d;
  logic [sst_pkg::PRIO_W-1:0]   rem_q, rem_d;
  logic [sst_pkg::PRIO_W-1:0]   dsr_q, dsr_d;
  logic [sst_pkg::PRIO_W:0]     shifted;
  logic [sst_pkg::PRIO_W:0]     diff;
  logic                         qbit;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    shifted = {rem_q, quo_q[sst_pkg::BIG_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    qbit    = (shifted >= {1'b0, dsr_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = (divisor_i == '0) ? sst_pkg::PRIO_W'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? diff[sst_pkg::PRIO_W-1:0] : shifted[sst_pkg::PRIO_W-1:0];
      quo_d = {quo_q[sst_pkg::BIG_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign ready_o    = !busy_q && !start_i;

endmodule

// ===== rtl/stride_scheduler_table.sv =====
// Allocate and schedule scan the whole table: S_SCAN, S_FIN, S_UPD, S_DONE, then the output register.
// Make-runnable, yield and exit do one read-modify-write: S_ONE, S_DONE, then the output register.
// Errors found at accept and undefined operations go straight to S_DONE and the output register.
// A new word is taken only once S_DONE has passed its result to the output register.
// A config write, and reset release, start a division that holds off new words until it ends.
// Reset clears all control state; every slot then reads as free and next id is one.
// ----------------------------------------------------------------------------
// Stride scheduler task table
// Slot table in one synchronous memory, walked by a sequencer that scans,
// reads, modifies and writes back one entry per cycle.
// ----------------------------------------------------------------------------
`include "stride_scheduler_table_assert.svh"

module stride_scheduler_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] operation, [6:3] slot, [7] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [5:2] chosen_slot, [36:6] task_id
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Configuration registers.
  logic                          cfg_we;
  logic [sst_pkg::BIG_W-1:0]     big_stride_q, big_stride_d;
  logic [sst_pkg::PRIO_W-1:0]    prio_q, prio_d;
  logic                          init_q;
  logic                          div_ready;
  logic [sst_pkg::BIG_W-1:0]     step;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sst_pkg::REG_PRIORITY) ? 32'(prio_q) : big_stride_q;

  assign big_stride_d = (cfg_we && paddr[2] == sst_pkg::REG_BIG_STRIDE) ? pwdata
                                                                         : big_stride_q;
  assign prio_d       = (cfg_we && paddr[2] == sst_pkg::REG_PRIORITY)
                        ? pwdata[sst_pkg::PRIO_W-1:0] : prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_stride_q <= sst_pkg::BIG_STRIDE_RST;
      prio_q       <= sst_pkg::PRIO_RST;
      init_q       <= 1'b1;
    end else begin
      init_q       <= 1'b0;
      big_stride_q <= big_stride_d;
      prio_q       <= prio_d;
    end
  end

  sst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (init_q || cfg_we),
    .dividend_i (big_stride_d),
    .divisor_i  (prio_d),
    .quotient_o (step),
    .ready_o    (div_ready)
  );

  // Slot memory and its valid bits.
  sst_pkg::slot_entry_t mem_q [SLOTS];
  logic [SLOTS-1:0]     slot_valid_q;
  sst_pkg::slot_entry_t rd_data_q;
  logic [SLOT_W-1:0]    rd_idx_q;
  logic                 rd_ok_q;
  logic                 rd_vld_q;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  sst_pkg::slot_entry_t wr_data;
  logic [1:0]           rd_state;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
    rd_idx_q  <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      rd_ok_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_valid_q[wr_addr] <= 1'b1;
      end
      rd_ok_q  <= rd_en;
      rd_vld_q <= slot_valid_q[rd_addr];
    end
  end

  assign rd_state = rd_vld_q ? rd_data_q.st : sst_pkg::SLOT_FREE;

  // Sequencer.
  sst_pkg::fsm_e                 state_q, state_d;
  logic [2:0]                    op_q, op_d;
  logic [SLOT_W-1:0]             iss_q, iss_d;
  logic                          found_q, found_d;
  logic [SLOT_W-1:0]             best_idx_q, best_idx_d;
  logic [sst_pkg::STRIDE_W-1:0]  best_stride_q, best_stride_d;
  logic [sst_pkg::ID_W-1:0]      best_id_q, best_id_d;
  logic [SLOT_W-1:0]             cur_slot_q, cur_slot_d;
  logic                          cur_valid_q, cur_valid_d;
  logic [sst_pkg::ID_W-1:0]      next_id_q, next_id_d;
  logic [1:0]                    res_status_q, res_status_d;
  logic [3:0]                    res_slot_q, res_slot_d;
  logic [sst_pkg::ID_W-1:0]      res_id_q, res_id_d;
  logic [2:0]                    in_op;
  logic [3:0]                    in_slot;
  logic                          in_range;
  logic                          accept;
  logic                          out_load;
  logic                          m_valid_q;
  logic [39:0]                   m_data_q;

  assign in_op         = s_axis_tdata[2:0];
  assign in_slot       = s_axis_tdata[6:3];
  assign in_range      = (32'(in_slot) < SLOTS);
  assign s_axis_tready = (state_q == sst_pkg::S_IDLE) && div_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == sst_pkg::S_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    iss_d         = iss_q;
    found_d       = found_q;
    best_idx_d    = best_idx_q;
    best_stride_d = best_stride_q;
    best_id_d     = best_id_q;
    cur_slot_d    = cur_slot_q;
    cur_valid_d   = cur_valid_q;
    next_id_d     = next_id_q;
    res_status_d  = res_status_q;
    res_slot_d    = res_slot_q;
    res_id_d      = res_id_q;
    rd_addr       = '0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    unique case (state_q) inside
      sst_pkg::S_IDLE: begin
        if (accept) begin
          op_d          = in_op;
          res_status_d  = sst_pkg::STAT_OK;
          res_slot_d    = '0;
          res_id_d      = '0;
          iss_d         = '0;
          found_d       = 1'b0;
          best_idx_d    = '0;
          best_stride_d = '1;
          case (in_op) inside
            sst_pkg::OP_ALLOC, sst_pkg::OP_SCHED: begin
              state_d = sst_pkg::S_SCAN;
            end
            sst_pkg::OP_RUN: begin
              if (in_range) begin
                rd_addr = SLOT_W'(in_slot);
                rd_en   = 1'b1;
                state_d = sst_pkg::S_ONE;
              end else begin
                res_status_d = sst_pkg::STAT_NOSLOT;
                state_d      = sst_pkg::S_DONE;
              end
            end
            sst_pkg::OP_YIELD, sst_pkg::OP_EXIT: begin
              if (cur_valid_q) begin
                rd_addr = cur_slot_q;
                rd_en   = 1'b1;
                state_d = sst_pkg::S_ONE;
              end else begin
                res_status_d = sst_pkg::STAT_NOCUR;
                state_d      = sst_pkg::S_DONE;
              end
            end
            default: begin
              state_d = sst_pkg::S_DONE;
            end
          endcase
        end
      end
      sst_pkg::S_SCAN, sst_pkg::S_FIN: begin
        if (state_q == sst_pkg::S_SCAN) begin
          rd_addr = iss_q;
          rd_en   = 1'b1;
          iss_d   = iss_q + 1'b1;
          if (iss_q == LAST_SLOT) begin
            state_d = sst_pkg::S_FIN;
          end
        end else begin
          state_d = sst_pkg::S_UPD;
        end
        if (rd_ok_q) begin
          if (op_q == sst_pkg::OP_ALLOC) begin
            if (!found_q && rd_state == sst_pkg::SLOT_FREE) begin
              found_d    = 1'b1;
              best_idx_d = rd_idx_q;
            end
          end else if (rd_state == sst_pkg::SLOT_RUNNABLE &&
                       rd_data_q.stride < best_stride_q) begin
            found_d       = 1'b1;
            best_idx_d    = rd_idx_q;
            best_stride_d = rd_data_q.stride;
            best_id_d     = rd_data_q.task_id;
          end
        end
      end
      sst_pkg::S_UPD: begin
        state_d = sst_pkg::S_DONE;
        if (!found_q) begin
          res_status_d = sst_pkg::STAT_NOSLOT;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = best_idx_q;
          res_slot_d = 4'(best_idx_q);
          if (op_q == sst_pkg::OP_ALLOC) begin
            wr_data.st      = sst_pkg::SLOT_USED;
            wr_data.stride  = '0;
            wr_data.task_id = next_id_q;
            res_id_d        = next_id_q;
            next_id_d       = next_id_q + 1'b1;
          end else begin
            wr_data.st      = sst_pkg::SLOT_RUNNING;
            wr_data.stride  = best_stride_q + sst_pkg::STRIDE_W'(step);
            wr_data.task_id = best_id_q;
            res_id_d        = best_id_q;
            cur_slot_d      = best_idx_q;
            cur_valid_d     = 1'b1;
          end
        end
      end
      sst_pkg::S_ONE: begin
        state_d = sst_pkg::S_DONE;
        wr_addr = rd_idx_q;
        wr_data = rd_data_q;
        if (op_q == sst_pkg::OP_RUN && rd_state == sst_pkg::SLOT_FREE) begin
          res_status_d = sst_pkg::STAT_NOSLOT;
        end else begin
          wr_en      = 1'b1;
          res_slot_d = 4'(rd_idx_q);
          res_id_d   = rd_data_q.task_id;
          if (op_q == sst_pkg::OP_EXIT) begin
            wr_data.st = sst_pkg::SLOT_FREE;
          end else begin
            wr_data.st = sst_pkg::SLOT_RUNNABLE;
          end
          if (op_q != sst_pkg::OP_RUN || cur_slot_q == rd_idx_q) begin
            cur_valid_d = 1'b0;
          end
        end
      end
      sst_pkg::S_DONE: begin
        if (out_load) begin
          state_d = sst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::S_IDLE;
      op_q        <= sst_pkg::OP_ALLOC;
      iss_q       <= '0;
      found_q     <= 1'b0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      next_id_q   <= sst_pkg::ID_RST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      iss_q       <= iss_d;
      found_q     <= found_d;
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      next_id_q   <= next_id_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q    <= best_idx_d;
    best_stride_q <= best_stride_d;
    best_id_q     <= best_id_d;
    res_status_q  <= res_status_d;
    res_slot_q    <= res_slot_d;
    res_id_q      <= res_id_d;
    if (out_load) begin
      m_data_q <= {3'b000, res_id_q, res_slot_q, res_status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SST_ASSERT_IMP(a_err_zero, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] != sst_pkg::STAT_OK,
    m_axis_tdata[36:2] == '0, "Error result carries a slot or an identifier.")
  `SST_ASSERT_IMP(a_scan_last, clk_i, rst_ni, state_q == sst_pkg::S_FIN,
    rd_ok_q && rd_idx_q == LAST_SLOT, "Scan did not end on the last slot.")
  `SST_ASSERT_NXT(a_sched_cur, clk_i, rst_ni,
    state_q == sst_pkg::S_UPD && found_q && op_q == sst_pkg::OP_SCHED,
    cur_valid_q, "Scheduled slot did not become current.")
  `SST_ASSERT_IMP(a_div_hold, clk_i, rst_ni, !div_ready, !s_axis_tready,
    "Word accepted while the stride step is being computed.")

endmodule

// ===== bench/stride_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stride scheduler table checker
// Watches the register port and both streams. It keeps its own copy of the
// slot table, the identifier counter, the current pointer and the two
// registers. For every accepted command word it works out the reply word,
// and it compares every accepted reply word field by field with the oldest
// reply still owed.
// ----------------------------------------------------------------------------
module stride_table_checker
  import sst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        apb_sel_i,
  input  logic        apb_enable_i,
  input  logic        apb_write_i,
  input  logic        apb_ready_i,
  input  logic [2:0]  apb_addr_i,
  input  logic [31:0] apb_wdata_i,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [7:0]  cmd_data_i,   // [2:0] operation, [6:3] slot, [7] zero
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [39:0] rsp_data_i,   // [1:0] status, [5:2] chosen_slot, [36:6] task_id
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic [3:0]      chosen_slot;
    logic [1:0]      status;
  } table_reply_t;

  logic [1:0]          slot_state   [SLOTS];
  logic [STRIDE_W-1:0] slot_stride  [SLOTS];
  logic [ID_W-1:0]     slot_task_id [SLOTS];
  logic [ID_W-1:0]     next_task_id;
  int unsigned         cur_slot;
  logic                cur_valid;
  logic [BIG_W-1:0]    big_stride;
  logic [PRIO_W-1:0]   task_priority;

  table_reply_t replies_owed[$];
  int unsigned  mismatch_count = 0;

  function automatic table_reply_t apply_table_op(input logic [2:0] op, input logic [3:0] sl);
    table_reply_t        r;
    int                  pick;
    int                  i;
    logic [STRIDE_W-1:0] best;
    logic [BIG_W-1:0]    step;
    r    = '0;
    pick = -1;
    best = '1;
    case (op)
      OP_ALLOC: begin
        for (i = 0; i < SLOTS; i++) begin
          if (pick < 0 && slot_state[i] == SLOT_FREE) pick = i;
        end
        if (pick < 0) begin
          r.status = STAT_NOSLOT;
        end else begin
          slot_state[pick]   = SLOT_USED;
          slot_stride[pick]  = '0;
          slot_task_id[pick] = next_task_id;
          next_task_id       = next_task_id + 1'b1;
          r.status           = STAT_OK;
          r.chosen_slot      = pick[3:0];
          r.task_id          = slot_task_id[pick];
        end
      end
      OP_RUN: begin
        if (sl >= SLOTS || slot_state[sl] == SLOT_FREE) begin
          r.status = STAT_NOSLOT;
        end else begin
          slot_state[sl] = SLOT_RUNNABLE;
          if (cur_valid && cur_slot == sl) cur_valid = 1'b0;
          r.status      = STAT_OK;
          r.chosen_slot = sl;
          r.task_id     = slot_task_id[sl];
        end
      end
      OP_YIELD, OP_EXIT: begin
        if (!cur_valid) begin
          r.status = STAT_NOCUR;
        end else begin
          slot_state[cur_slot] = (op == OP_YIELD) ? SLOT_RUNNABLE : SLOT_FREE;
          cur_valid            = 1'b0;
          r.status             = STAT_OK;
          r.chosen_slot        = cur_slot[3:0];
          r.task_id            = slot_task_id[cur_slot];
        end
      end
      OP_SCHED: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_state[i] == SLOT_RUNNABLE && slot_stride[i] < best) begin
            best = slot_stride[i];
            pick = i;
          end
        end
        if (pick < 0) begin
          r.status = STAT_NOSLOT;
        end else begin
          step              = big_stride / ((task_priority == '0) ? 8'd1 : task_priority);
          slot_state[pick]  = SLOT_RUNNING;
          slot_stride[pick] = slot_stride[pick] + {{(STRIDE_W-BIG_W){1'b0}}, step};
          cur_slot          = pick;
          cur_valid         = 1'b1;
          r.status          = STAT_OK;
          r.chosen_slot     = pick[3:0];
          r.task_id         = slot_task_id[pick];
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    table_reply_t got;
    int           i;
    if (!rst_ni) begin
      for (i = 0; i < SLOTS; i++) begin
        slot_state[i]   = SLOT_FREE;
        slot_stride[i]  = '0;
        slot_task_id[i] = '0;
      end
      next_task_id  = ID_RST;
      cur_slot      = 0;
      cur_valid     = 1'b0;
      big_stride    = BIG_STRIDE_RST;
      task_priority = PRIO_RST;
      replies_owed.delete();
    end else begin
      if (apb_sel_i && apb_enable_i && apb_write_i && apb_ready_i) begin
        if (apb_addr_i[2] == REG_BIG_STRIDE) begin
          big_stride = apb_wdata_i;
        end else begin
          task_priority = apb_wdata_i[PRIO_W-1:0];
        end
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_data_i[36:0];
        if (replies_owed.size() == 0) begin
          $display("%0t: reply word with none expected, actual status %0d slot %0d id %0d",
                   $time, got.status, got.chosen_slot, got.task_id);
          mismatch_count++;
        end else begin
          want = replies_owed.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.chosen_slot !== want.chosen_slot) begin
            $display("%0t: chosen_slot mismatch, expected %0d, actual %0d",
                     $time, want.chosen_slot, got.chosen_slot);
            mismatch_count++;
          end
          if (got.task_id !== want.task_id) begin
            $display("%0t: task_id mismatch, expected %0d, actual %0d",
                     $time, want.task_id, got.task_id);
            mismatch_count++;
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        replies_owed.push_back(apply_table_op(cmd_data_i[2:0], cmd_data_i[6:3]));
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= replies_owed.size();
  end

endmodule

// ===== bench/tb_stride_scheduler_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stride scheduler table testbench
// Drives command words through a directed opening and then several random
// phases, each under its own stride step settings written over the register
// port while the table is idle. Commands go out in bursts with random gaps,
// and the reply side stalls on a pattern of its own. A separate checker
// predicts and compares every reply word.
// ----------------------------------------------------------------------------
module tb_stride_scheduler_table;
  import sst_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 265;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef enum int unsigned {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [2:0] operation, [6:3] slot, [7] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [1:0] status, [5:2] chosen_slot, [36:6] task_id

  int unsigned mismatches;
  int unsigned pending;
  int unsigned burst_left  = 0;
  int unsigned rx_left     = 0;
  int unsigned cycle_count = 0;
  rx_mode_e    rx_mode     = RX_OPEN;

  logic [31:0]       phase_big  [PHASES] = '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                                             32'd0, 32'd0, 32'd65536};
  logic [PRIO_W-1:0] phase_prio [PHASES] = '{8'd255, 8'd2, 8'd0, 8'd1, 8'd0, 8'd16};

  stride_scheduler_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  stride_table_checker #(
    .SLOTS(SLOTS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apb_sel_i   (psel),
    .apb_enable_i(penable),
    .apb_write_i (pwrite),
    .apb_ready_i (pready),
    .apb_addr_i  (paddr),
    .apb_wdata_i (pwdata),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_i (s_axis_tready),
    .cmd_data_i  (s_axis_tdata),
    .rsp_valid_i (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_SPARSE));
      rx_left = $urandom_range(8, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      RX_HALF: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 4) == 0);
      end
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic issue_op(input logic [2:0] op, input logic [3:0] sl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sl, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned pick;
    logic [2:0]  op;
    phase_big[4]  = $urandom;
    phase_prio[4] = PRIO_W'($urandom_range(2, 255));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: no current task, nothing runnable, free slot named.
    issue_op(OP_YIELD, 4'd0);
    issue_op(OP_EXIT, 4'hF);
    issue_op(OP_SCHED, 4'd0);
    issue_op(OP_RUN, 4'hF);
    repeat (SLOTS) issue_op(OP_ALLOC, 4'($urandom_range(0, 15)));
    issue_op(OP_ALLOC, 4'd0);
    // Equal strides go to the lowest index; scheduling again while a task
    // is current leaves the old one running.
    issue_op(OP_RUN, 4'd0);
    issue_op(OP_RUN, 4'hF);
    issue_op(OP_SCHED, 4'd0);
    issue_op(OP_SCHED, 4'd0);
    issue_op(OP_YIELD, 4'd0);
    issue_op(OP_SCHED, 4'd0);
    issue_op(OP_EXIT, 4'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      apb_write({REG_BIG_STRIDE, 2'b00}, phase_big[ph]);
      apb_write({REG_PRIORITY, 2'b00}, {24'd0, phase_prio[ph]});
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
          op = OP_ALLOC;
        end else if (pick < 43) begin
          op = OP_RUN;
        end else if (pick < 70) begin
          op = OP_SCHED;
        end else if (pick < 82) begin
          op = OP_YIELD;
        end else if (pick < 94) begin
          op = OP_EXIT;
        end else begin
          op = OP_SCHED + 3'($urandom_range(1, 3));
        end
        issue_op(op, 4'($urandom_range(0, 15)));
      end
    end

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== stride_scheduler_table.f =====
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_div.sv
rtl/stride_scheduler_table.sv
bench/stride_table_checker.sv
bench/tb_stride_scheduler_table.sv
